@@ design/laser_ray_occupancy_grid_update_top_defines.svh @@
// Assertion macros for the occupancy grid mapper
`ifndef LASER_RAY_OCCUPANCY_GRID_UPDATE_TOP_DEFINES_SVH
`define LASER_RAY_OCCUPANCY_GRID_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LROG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LROG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lrog_pkg.sv @@
// Types, constants and sine helpers for the occupancy grid mapper
`default_nettype none
package lrog_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic [15:0]        pose_heading;
    logic [9:0]         beam_index;
    logic [15:0]        beam_range_mm;
    logic [8:0]         read_row;
    logic [8:0]         read_col;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] cell_value;
    logic       beam_used;
  } out_beat_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } grid_ctl_t;

  typedef enum logic [1:0] {
    OP_POSE = 2'd0,
    OP_BEAM = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_MIN  = 3'd0,
    CFG_ANGLE_STEP = 3'd1,
    CFG_MAX_RANGE  = 3'd2,
    CFG_CELL_SCALE = 3'd3,
    CFG_OCC_THICK  = 3'd4
  } cfg_e;

  localparam logic [15:0] RST_ANGLE_MIN  = 16'd0;
  localparam logic [15:0] RST_ANGLE_STEP = 16'd102;
  localparam logic [9:0]  RST_MAX_RANGE  = 10'd100;
  localparam logic [15:0] RST_CELL_SCALE = 16'd256;
  localparam logic [15:0] RST_OCC_THICK  = 16'd667;

  localparam logic [7:0] MAP_OCC     = 8'd0;
  localparam logic [7:0] MAP_UNKNOWN = 8'd86;
  localparam logic [7:0] MAP_FREE    = 8'd172;
  localparam logic [7:0] MAP_ROBOT   = 8'd255;

  localparam int MUL_W  = 21;
  localparam int PROD_W = 42;
  localparam int NUM_W  = 44;
  localparam int CRD_W  = 19;

  // march numerator / (5 * 2^23): shift, then multiply by 2^22/5 rounded up
  localparam int          DIV_SHIFT   = 23;
  localparam logic [19:0] RECIP5      = 20'd838861;
  localparam int          RECIP5_LSB  = 22;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [16:0] STEP_MM     = 17'd100;
  localparam logic [15:0] QUARTER     = 16'd16384;

  localparam logic [14:0] SINE_Q14 [65] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
    15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
    15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
    15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
    15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
    15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
    15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15790, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
    15'd16384
  };

  typedef struct packed {
    logic [14:0] base;
    logic [8:0]  diff;
    logic [7:0]  frac;
    logic        neg;
  } sine_parts_t;

  function automatic sine_parts_t sine_parts(input logic [15:0] a);
    logic [14:0] r;
    logic [6:0]  i;
    sine_parts_t p;
    r = {1'b0, a[13:0]};
    if (a[14]) begin
      r = 15'd16384 - r;
    end
    i = r[14:8];
    p.frac = r[7:0];
    p.neg  = a[15];
    if (i == 7'd64) begin
      p.base = 15'd16384;
      p.diff = '0;
    end else begin
      p.base = SINE_Q14[i];
      p.diff = 9'(SINE_Q14[7'(i + 7'd1)] - SINE_Q14[i]);
    end
    return p;
  endfunction

  function automatic logic signed [15:0] sine_finish(input sine_parts_t p,
                                                     input logic [8:0] prod_hi);
    logic signed [15:0] v;
    v = signed'({1'b0, 15'(p.base + 15'(prod_hi))});
    return p.neg ? -v : v;
  endfunction

endpackage
`default_nettype wire

@@ design/lrog_mul.sv @@
// Shared registered signed multiplier
`default_nettype none
module lrog_mul (
  input  logic                                clk_i,
  input  logic signed [lrog_pkg::MUL_W-1:0]   a_i,
  input  logic signed [lrog_pkg::MUL_W-1:0]   b_i,
  output logic signed [lrog_pkg::PROD_W-1:0]  p_o
);
  import lrog_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

@@ design/lrog_grid.sv @@
// Grid byte memory with clearing sweep after reset
`default_nettype none
module lrog_grid #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrog_pkg::grid_ctl_t  ctl_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [7:0]           wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [7:0]           rdata_o,
  output logic                 busy_o
);
  import lrog_pkg::*;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] clr_q;
  logic          busy_q;
  logic          wr_en;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  assign wr_en = busy_q | ctl_i.wr;
  assign wa    = busy_q ? clr_q : waddr_i;
  assign wd    = busy_q ? MAP_UNKNOWN : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wa] <= wd;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;
endmodule
`default_nettype wire

@@ design/laser_ray_occupancy_grid_update_top.sv @@
// Occupancy grid mapper top level: sequencer, pose, configuration and result register
`default_nettype none
`include "laser_ray_occupancy_grid_update_top_defines.svh"
// After reset the grid is swept to unknown, one cell a cycle, over all GRID_ROWS*GRID_COLS
// cells; no item is taken meanwhile, configuration writes are. Then one item is worked
// at a time through a single registered multiplier, which a marched beam reuses for the
// row and column divide of every march step.
// A result sits in an output register, so the next item is taken while it waits.
module laser_ray_occupancy_grid_update_top #(
  parameter int GRID_ROWS   = 512,
  parameter int GRID_COLS   = 512,
  parameter int BEAM_STRIDE = 9,
  parameter int MAX_BEAMS   = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrog_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lrog_pkg::in_beat_t                in_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lrog_pkg::out_beat_t               out_beat_o
);
  import lrog_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int STRIDE_RECIP = ((1 << RECIP_SHIFT) + BEAM_STRIDE - 1) / BEAM_STRIDE;

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_POSE     = 17'h00002,
    ST_RD_ISSUE = 17'h00004,
    ST_RD_DATA  = 17'h00008,
    ST_B_MOD    = 17'h00010,
    ST_B_CHK    = 17'h00020,
    ST_B_ANG    = 17'h00040,
    ST_B_SIN0   = 17'h00080,
    ST_B_SIN1   = 17'h00100,
    ST_B_COS    = 17'h00200,
    ST_B_DR     = 17'h00400,
    ST_B_DC     = 17'h00800,
    ST_M_ROW    = 17'h01000,
    ST_M_COL    = 17'h02000,
    ST_M_RD     = 17'h04000,
    ST_M_WR     = 17'h08000,
    ST_DONE     = 17'h10000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] amin_q, astep_q, scale_q, thick_q;
  logic [9:0]  maxr_q;

  logic signed [15:0] rx_q, ry_q;
  logic [15:0]        head_q;
  logic               pose_valid_q;

  in_beat_t  item_q;
  logic [7:0] res_cell_q;
  logic       res_used_q;
  out_beat_t  out_q;
  logic       out_valid_q;

  logic [15:0]              ang_q;
  logic signed [15:0]       s_q, c_q;
  logic signed [NUM_W-1:0]  nr_q, nc_q, dr_q, dc_q;
  logic signed [CRD_W-1:0]  row_q;
  logic [9:0]               j_q;
  logic [16:0]              dist_q;
  logic [AW-1:0]            addr_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  grid_ctl_t     gctl;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [7:0]    g_wdata, g_rdata;
  logic          g_busy;

  logic accept;
  logic load_out;

  sine_parts_t sp, cp;
  logic [9:0]  stride_quot;
  logic        beam_ok;
  logic signed [NUM_W-1:0] nabs_r, nabs_c, xe, ye;
  logic signed [CRD_W-1:0] col_now, robot_r, robot_c, rd_r, rd_c;
  logic [AW-1:0] cur_addr, robot_addr, rd_addr;
  logic cur_in, robot_in, rd_in, last_step;
  logic [17:0] far_mm;

  function automatic logic in_grid(input logic signed [CRD_W-1:0] r,
                                   input logic signed [CRD_W-1:0] c);
    return !r[CRD_W-1] && (r < CRD_W'(GRID_ROWS)) &&
           !c[CRD_W-1] && (c < CRD_W'(GRID_COLS));
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [CRD_W-1:0] r,
                                              input logic signed [CRD_W-1:0] c);
    logic [CRD_W-1:0] ru, cu;
    ru = r;
    cu = c;
    return AW'(AW'(ru[RW-1:0]) * AW'(GRID_COLS)) + AW'(cu[CW-1:0]);
  endfunction

  function automatic logic signed [CRD_W-1:0] to_cell(input logic signed [PROD_W-1:0] p,
                                                      input logic neg, input int half);
    logic signed [CRD_W-1:0] q;
    q = signed'({1'b0, p[RECIP5_LSB+CRD_W-2:RECIP5_LSB]});
    return (neg ? -q : q) + CRD_W'(half);
  endfunction

  function automatic logic signed [CRD_W-1:0] robot_cell(input logic signed [15:0] v,
                                                         input int half);
    logic signed [CRD_W-1:0] t;
    t = CRD_W'(v >>> 8);
    if (v[15] && (v[7:0] != 8'd0)) begin
      t = t + CRD_W'(1);
    end
    return t + CRD_W'(half);
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || g_busy;

  assign sp = sine_parts(ang_q);
  assign cp = sine_parts(16'(ang_q + QUARTER));

  assign stride_quot = mul_p[RECIP_SHIFT+9:RECIP_SHIFT];
  assign beam_ok  = pose_valid_q && (13'(item_q.beam_index) < 13'(MAX_BEAMS)) &&
                    (17'(17'(stride_quot) * 17'(BEAM_STRIDE)) == 17'(item_q.beam_index));

  assign nabs_r = nr_q[NUM_W-1] ? -nr_q : nr_q;
  assign nabs_c = nc_q[NUM_W-1] ? -nc_q : nc_q;
  assign xe = NUM_W'(rx_q);
  assign ye = NUM_W'(ry_q);

  assign col_now  = to_cell(mul_p, nc_q[NUM_W-1], GRID_COLS / 2);
  assign cur_in   = in_grid(row_q, col_now);
  assign cur_addr = cell_addr(row_q, col_now);

  assign robot_r    = robot_cell(rx_q, GRID_ROWS / 2);
  assign robot_c    = robot_cell(ry_q, GRID_COLS / 2);
  assign robot_in   = in_grid(robot_r, robot_c);
  assign robot_addr = cell_addr(robot_r, robot_c);

  assign rd_r    = CRD_W'(item_q.read_row);
  assign rd_c    = CRD_W'(item_q.read_col);
  assign rd_in   = in_grid(rd_r, rd_c);
  assign rd_addr = cell_addr(rd_r, rd_c);

  assign last_step = (11'(j_q) + 11'd1) >= 11'(maxr_q);
  assign far_mm    = 18'(item_q.beam_range_mm) + 18'(thick_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_B_MOD: begin
        mul_a = MUL_W'(item_q.beam_index);
        mul_b = MUL_W'(STRIDE_RECIP);
      end
      ST_B_CHK: begin
        mul_a = MUL_W'(item_q.beam_index);
        mul_b = MUL_W'(astep_q);
      end
      ST_B_SIN0: begin
        mul_a = MUL_W'(sp.diff);
        mul_b = MUL_W'(sp.frac);
      end
      ST_B_SIN1: begin
        mul_a = MUL_W'(cp.diff);
        mul_b = MUL_W'(cp.frac);
      end
      ST_B_COS: begin
        mul_a = MUL_W'(s_q);
        mul_b = MUL_W'(scale_q);
      end
      ST_B_DR: begin
        mul_a = MUL_W'(c_q);
        mul_b = MUL_W'(scale_q);
      end
      ST_M_ROW: begin
        mul_a = MUL_W'(nabs_r[DIV_SHIFT+19:DIV_SHIFT]);
        mul_b = MUL_W'(RECIP5);
      end
      ST_M_COL: begin
        mul_a = MUL_W'(nabs_c[DIV_SHIFT+19:DIV_SHIFT]);
        mul_b = MUL_W'(RECIP5);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    gctl    = '0;
    g_waddr = addr_q;
    g_wdata = MAP_FREE;
    g_raddr = cur_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_beat_i.op)
            OP_POSE: state_d = ST_POSE;
            OP_BEAM: state_d = ST_B_MOD;
            OP_READ: state_d = ST_RD_ISSUE;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_POSE: begin
        gctl.wr = robot_in;
        g_waddr = robot_addr;
        g_wdata = MAP_ROBOT;
        state_d = ST_DONE;
      end
      ST_RD_ISSUE: begin
        gctl.rd = rd_in;
        g_raddr = rd_addr;
        state_d = rd_in ? ST_RD_DATA : ST_DONE;
      end
      ST_RD_DATA: state_d = ST_DONE;
      ST_B_MOD:   state_d = ST_B_CHK;
      ST_B_CHK:   state_d = beam_ok ? ST_B_ANG : ST_DONE;
      ST_B_ANG:   state_d = ST_B_SIN0;
      ST_B_SIN0:  state_d = ST_B_SIN1;
      ST_B_SIN1:  state_d = ST_B_COS;
      ST_B_COS:   state_d = ST_B_DR;
      ST_B_DR:    state_d = ST_B_DC;
      ST_B_DC:    state_d = (maxr_q == 10'd0) ? ST_DONE : ST_M_ROW;
      ST_M_ROW:   state_d = ST_M_COL;
      ST_M_COL:   state_d = ST_M_RD;
      ST_M_RD: begin
        gctl.rd = cur_in;
        if (cur_in) begin
          state_d = ST_M_WR;
        end else begin
          state_d = last_step ? ST_DONE : ST_M_ROW;
        end
      end
      ST_M_WR: begin
        if (17'(item_q.beam_range_mm) > dist_q) begin
          gctl.wr = (g_rdata != MAP_ROBOT);
          g_wdata = MAP_FREE;
        end else if ((17'(item_q.beam_range_mm) < dist_q) && (far_mm > 18'(dist_q))) begin
          gctl.wr = 1'b1;
          g_wdata = MAP_OCC;
        end
        state_d = last_step ? ST_DONE : ST_M_ROW;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pose_valid_q <= 1'b0;
      rx_q         <= '0;
      ry_q         <= '0;
      head_q       <= '0;
      amin_q       <= RST_ANGLE_MIN;
      astep_q      <= RST_ANGLE_STEP;
      maxr_q       <= RST_MAX_RANGE;
      scale_q      <= RST_CELL_SCALE;
      thick_q      <= RST_OCC_THICK;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept && (in_beat_i.op == OP_POSE)) begin
        rx_q         <= in_beat_i.pose_x;
        ry_q         <= in_beat_i.pose_y;
        head_q       <= in_beat_i.pose_heading;
        pose_valid_q <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ANGLE_MIN:  amin_q  <= cfg_data_i;
          CFG_ANGLE_STEP: astep_q <= cfg_data_i;
          CFG_MAX_RANGE:  maxr_q  <= cfg_data_i[9:0];
          CFG_CELL_SCALE: scale_q <= cfg_data_i;
          CFG_OCC_THICK:  thick_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  logic step_adv;
  assign step_adv = (state_q == ST_M_WR) || ((state_q == ST_M_RD) && !cur_in);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_beat_i;
      res_cell_q <= '0;
      res_used_q <= 1'b0;
    end
    if (state_q == ST_RD_ISSUE && !rd_in) begin
      res_cell_q <= MAP_UNKNOWN;
    end
    if (state_q == ST_RD_DATA) begin
      res_cell_q <= g_rdata;
    end
    if (state_q == ST_B_ANG) begin
      ang_q      <= 16'(head_q + amin_q + mul_p[15:0]);
      res_used_q <= 1'b1;
    end
    if (state_q == ST_B_SIN1) begin
      s_q <= sine_finish(sp, mul_p[16:8]);
    end
    if (state_q == ST_B_COS) begin
      c_q <= sine_finish(cp, mul_p[16:8]);
    end
    if (state_q == ST_B_DR) begin
      dr_q <= -NUM_W'(mul_p);
      nr_q <= ((xe <<< 2) + xe) <<< 15;
    end
    if (state_q == ST_B_DC) begin
      dc_q   <= NUM_W'(mul_p);
      nc_q   <= ((ye <<< 2) + ye) <<< 15;
      j_q    <= '0;
      dist_q <= '0;
    end
    if (state_q == ST_M_COL) begin
      row_q <= to_cell(mul_p, nr_q[NUM_W-1], GRID_ROWS / 2);
    end
    if (state_q == ST_M_RD) begin
      addr_q <= cur_addr;
    end
    if (step_adv) begin
      nr_q   <= nr_q + dr_q;
      nc_q   <= nc_q + dc_q;
      j_q    <= j_q + 10'd1;
      dist_q <= dist_q + STEP_MM;
    end
    if (load_out) begin
      out_q.cell_value <= res_cell_q;
      out_q.beam_used  <= res_used_q;
    end
  end

  lrog_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lrog_grid #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (gctl),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata),
    .busy_o  (g_busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `LROG_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, in_stall_o, "input taken while busy")
  `LROG_ASSERT_NOW(a_no_access_in_clear, g_busy, !gctl.wr && !gctl.rd, "grid access in clear")
  `LROG_ASSERT_NEXT(a_beam_starts, accept && (in_beat_i.op == OP_BEAM), state_q == ST_B_MOD,
                    "beam beat did not start")
endmodule
`default_nettype wire

@@ verif/lrog_checker.sv @@
// Occupancy grid mapper checker: tracks grid and pose, predicts each result beat, compares
`default_nettype none
module lrog_checker #(
  parameter int GRID_ROWS   = 512,
  parameter int GRID_COLS   = 512,
  parameter int BEAM_STRIDE = 9,
  parameter int MAX_BEAMS   = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lrog_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  lrog_pkg::in_beat_t             in_beat_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  lrog_pkg::out_beat_t            out_beat_i,
  output int                             errors_o,
  output int                             pending_o
);
  import lrog_pkg::*;

  logic [7:0]  cells [GRID_ROWS*GRID_COLS];
  int          rob_x, rob_y;
  logic [15:0] rob_head;
  logic        mapping_on;
  logic [15:0] amin, astep, cscale, othick;
  logic [9:0]  nsteps;
  logic        swept;
  out_beat_t   expected_q [$];

  function automatic int sin_q14(input logic [15:0] a);
    int r, i, f, v;
    r = int'(a[13:0]);
    if (a[14]) begin
      r = 16384 - r;
    end
    i = r >> 8;
    f = r & 255;
    if (i >= 64) begin
      v = 16384;
    end else begin
      v = int'(SINE_Q14[i]) + (((int'(SINE_Q14[i+1]) - int'(SINE_Q14[i])) * f) >> 8);
    end
    return a[15] ? -v : v;
  endfunction

  function automatic bit on_grid(input longint r, input longint c);
    return r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS;
  endfunction

  function automatic void march(input logic [9:0] idx, input logic [15:0] rng);
    logic [15:0] ang;
    longint s, c, bx, by, k, r, col;
    int span_mm, a;
    ang = 16'(32'(rob_head) + 32'(amin) + 32'(idx) * 32'(astep));
    s = sin_q14(ang);
    c = sin_q14(16'(ang + QUARTER));
    bx = longint'(rob_x) * 163840;
    by = longint'(rob_y) * 163840;
    for (int j = 0; j < int'(nsteps); j++) begin
      k = longint'(j) * longint'(cscale);
      r = (bx - s * k) / 41943040 + GRID_ROWS / 2;
      col = (by + c * k) / 41943040 + GRID_COLS / 2;
      span_mm = j * 100;
      if (on_grid(r, col)) begin
        a = int'(r) * GRID_COLS + int'(col);
        if (int'(rng) > span_mm) begin
          if (cells[a] != MAP_ROBOT) begin
            cells[a] = MAP_FREE;
          end
        end else if (int'(rng) < span_mm && int'(rng) + int'(othick) > span_mm) begin
          cells[a] = MAP_OCC;
        end
      end
    end
  endfunction

  function automatic out_beat_t predict_cell(input in_beat_t b);
    out_beat_t o;
    longint r, c;
    o = '0;
    case (op_e'(b.op))
      OP_POSE: begin
        rob_x = int'(b.pose_x);
        rob_y = int'(b.pose_y);
        rob_head = b.pose_heading;
        mapping_on = 1'b1;
        r = rob_x / 256 + GRID_ROWS / 2;
        c = rob_y / 256 + GRID_COLS / 2;
        if (on_grid(r, c)) begin
          cells[int'(r) * GRID_COLS + int'(c)] = MAP_ROBOT;
        end
      end
      OP_BEAM: begin
        if (mapping_on && int'(b.beam_index) < MAX_BEAMS &&
            int'(b.beam_index) % BEAM_STRIDE == 0) begin
          march(b.beam_index, b.beam_range_mm);
          o.beam_used = 1'b1;
        end
      end
      OP_READ: begin
        r = longint'(b.read_row);
        c = longint'(b.read_col);
        o.cell_value = on_grid(r, c) ? cells[int'(r) * GRID_COLS + int'(c)] : MAP_UNKNOWN;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      if (!swept) begin
        foreach (cells[i]) cells[i] = MAP_UNKNOWN;
        swept = 1'b1;
      end
      rob_x = 0;
      rob_y = 0;
      rob_head = '0;
      mapping_on = 1'b0;
      amin = RST_ANGLE_MIN;
      astep = RST_ANGLE_STEP;
      nsteps = RST_MAX_RANGE;
      cscale = RST_CELL_SCALE;
      othick = RST_OCC_THICK;
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_ANGLE_MIN:  amin = cfg_data_i;
          CFG_ANGLE_STEP: astep = cfg_data_i;
          CFG_MAX_RANGE:  nsteps = cfg_data_i[9:0];
          CFG_CELL_SCALE: cscale = cfg_data_i;
          CFG_OCC_THICK:  othick = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("unexpected result beat %p", out_beat_i);
          end
        end else begin
          want = expected_q.pop_front();
          if (out_beat_i.cell_value !== want.cell_value ||
              out_beat_i.beam_used !== want.beam_used) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("mismatch: cell_value exp %0d got %0d, beam_used exp %0d got %0d",
                       want.cell_value, out_beat_i.cell_value,
                       want.beam_used, out_beat_i.beam_used);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_cell(in_beat_i));
      end
    end
    pending_o = expected_q.size();
  end

  initial begin
    swept = 1'b0;
    errors_o = 0;
    pending_o = 0;
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Occupancy grid mapper testbench top: stimulus, config phases, stall patterns and verdict
`default_nettype none
module tb;
  import lrog_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [15:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_beat_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_beat_o;
  int                   errors, pending;
  int                   idle_cycles = 0;
  int                   cyc = 0;
  int                   burst_left = 0;
  int                   pose_row = 256, pose_col = 256;

  localparam int WATCHDOG = 1000000;

  laser_ray_occupancy_grid_update_top DUT (.*);

  lrog_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_beat_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_beat_i(out_beat_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver stall pattern cycles through free, light and heavy back-pressure
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc >> 9) % 3)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(input in_beat_t b);
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (b.op == OP_POSE) begin
      pose_row = int'(b.pose_x) / 256 + 256;
      pose_col = int'(b.pose_y) / 256 + 256;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] am, input logic [15:0] as,
                            input logic [15:0] mr, input logic [15:0] cs,
                            input logic [15:0] ot);
    logic [15:0] v [5];
    v = '{am, as, mr, cs, ot};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_beat_t mk(input op_e op);
    in_beat_t b;
    b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom, $urandom}));
    b.op = op;
    return b;
  endfunction

  function automatic int near(input int centre);
    int v;
    v = centre + $urandom_range(0, 40) - 20;
    return v < 0 ? 0 : (v > 511 ? 511 : v);
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      b = mk(OP_POSE);
      if ($urandom_range(0, 3) != 0) begin
        b.pose_x = 16'($urandom_range(0, 24000) - 12000);
        b.pose_y = 16'($urandom_range(0, 24000) - 12000);
      end
    end else if (pick < 60) begin
      b = mk(OP_BEAM);
      if ($urandom_range(0, 4) != 0) begin
        b.beam_index = 10'(9 * $urandom_range(0, 113));
      end
      if ($urandom_range(0, 3) != 0) begin
        b.beam_range_mm = 16'($urandom_range(0, 16000));
      end
    end else if (pick < 95) begin
      b = mk(OP_READ);
      if ($urandom_range(0, 9) < 7) begin
        b.read_row = 9'(near(pose_row));
        b.read_col = 9'(near(pose_col));
      end
    end else begin
      b = mk(OP_NONE);
    end
    return b;
  endfunction

  initial begin
    in_beat_t b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: skipped beam before pose, stride edges, pose extremes, grid corners
    b = mk(OP_BEAM); b.beam_index = '0; send_beat(b);
    b = mk(OP_READ); b.read_row = 9'd256; b.read_col = 9'd256; send_beat(b);
    b = mk(OP_POSE); b.pose_x = '0; b.pose_y = '0; b.pose_heading = '0; send_beat(b);
    b = mk(OP_BEAM); b.beam_index = '0; b.beam_range_mm = 16'd1500; send_beat(b);
    b = mk(OP_BEAM); b.beam_index = 10'd1; send_beat(b);
    b = mk(OP_BEAM); b.beam_index = 10'd1023; send_beat(b);
    b = mk(OP_BEAM); b.beam_index = 10'd1017; b.beam_range_mm = 16'hFFFF; send_beat(b);
    b = mk(OP_BEAM); b.beam_index = 10'd9; b.beam_range_mm = '0; send_beat(b);
    for (int i = 0; i < 4; i++) begin
      b = mk(OP_READ); b.read_row = 9'(250 + 2 * i); b.read_col = 9'(256 + 3 * i);
      send_beat(b);
    end
    b = mk(OP_NONE); send_beat(b);
    b = mk(OP_POSE); b.pose_x = 16'sh8000; b.pose_y = 16'sh7FFF; b.pose_heading = 16'hFFFF;
    send_beat(b);
    b = mk(OP_BEAM); b.beam_index = 10'd18; b.beam_range_mm = 16'd3000; send_beat(b);
    b = mk(OP_READ); b.read_row = 9'd128; b.read_col = 9'd383; send_beat(b);
    b = mk(OP_POSE); b.pose_x = 16'sh7FFF; b.pose_y = 16'sh8000; b.pose_heading = QUARTER;
    send_beat(b);
    b = mk(OP_BEAM); b.beam_index = 10'd27; b.beam_range_mm = 16'd800; send_beat(b);
    b = mk(OP_READ); b.read_row = '0; b.read_col = '0; send_beat(b);
    b = mk(OP_READ); b.read_row = 9'd511; b.read_col = 9'd511; send_beat(b);
    b = mk(OP_READ); b.read_row = 9'd383; b.read_col = 9'd128; send_beat(b);
    for (int i = 0; i < 100; i++) send_beat(rand_beat());
    settle();

    write_regs('0, '0, '0, '0, '0);
    for (int i = 0; i < 60; i++) send_beat(rand_beat());
    settle();

    write_regs(16'hFFFF, 16'hFFFF, 16'd1023, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 25; i++) send_beat(rand_beat());
    settle();

    for (int p = 0; p < 4; p++) begin
      write_regs(16'($urandom), 16'($urandom), 16'($urandom_range(20, 150)),
                 16'($urandom_range(128, 1024)), 16'($urandom_range(0, 2000)));
      for (int i = 0; i < 130; i++) send_beat(rand_beat());
      settle();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/lrog_pkg.sv
design/lrog_mul.sv
design/lrog_grid.sv
design/laser_ray_occupancy_grid_update_top.sv
verif/lrog_checker.sv
verif/tb.sv
